### hw/rtl/tclb_pkg.sv
package tclb_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NUL       = 8'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_data;
    logic [5:0] line_count;
    logic [6:0] cursor_col;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SWEEP_ALL,
    OP_SWEEP_ROW,
    OP_SWEEP_COL0,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_WRITE_CHAR,
    OP_WRITE_TERM,
    OP_CLEAR_REGS,
    OP_READ,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_newline;
    logic       is_backspace;
    logic       need_scroll;
    logic       need_wrap;
    logic       row_last;
    logic       col_last;
    logic       out_free;
  } dp_status_t;

endpackage

### hw/rtl/tclb_ctrl.sv
module tclb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tclb_pkg::dp_status_t status,
  output tclb_pkg::dp_op_t    op
);
  import tclb_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_SCROLL_W,
    ST_WR_CHAR,
    ST_WR_TERM,
    ST_CLR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      ST_INIT: begin
        op = OP_SWEEP_ALL;
        if (status.row_last && status.col_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.cmd)
          CMD_PUT: begin
            if (status.is_newline) begin
              op        = OP_NEWLINE;
              state_nxt = status.need_scroll ? ST_SCROLL : ST_DONE;
            end else if (status.is_backspace) begin
              op        = OP_BACKSPACE;
              state_nxt = ST_DONE;
            end else if (status.need_wrap) begin
              op        = OP_NEWLINE;
              state_nxt = status.need_scroll ? ST_SCROLL_W : ST_WR_CHAR;
            end else begin
              op        = OP_WRITE_CHAR;
              state_nxt = ST_WR_TERM;
            end
          end
          CMD_CLEAR: begin
            op        = OP_CLEAR_REGS;
            state_nxt = ST_CLR;
          end
          CMD_READ: begin
            op        = OP_READ;
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SCROLL: begin
        op = OP_SWEEP_ROW;
        if (status.col_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL_W: begin
        op = OP_SWEEP_ROW;
        if (status.col_last) begin
          state_nxt = ST_WR_CHAR;
        end
      end
      ST_WR_CHAR: begin
        op        = OP_WRITE_CHAR;
        state_nxt = ST_WR_TERM;
      end
      ST_WR_TERM: begin
        op        = OP_WRITE_TERM;
        state_nxt = ST_DONE;
      end
      ST_CLR: begin
        op = OP_SWEEP_COL0;
        if (status.row_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          op        = OP_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/tclb_datapath.sv
module tclb_datapath #(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tclb_pkg::in_item_t   in_item,
  input  tclb_pkg::dp_op_t     op,
  output tclb_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tclb_pkg::out_item_t  out_item
);
  import tclb_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LW    = $clog2(ROWS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  logic [7:0] mem [DEPTH];

  in_item_t    item_r;
  out_item_t   out_item_r;
  logic        out_valid_r, out_valid_nxt;
  logic [LW-1:0] lines_r, lines_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] scroll_row_r;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [7:0]    rd_data_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [RW:0]   cur_sum;
  logic [RW-1:0] cur_row;
  logic [RW:0]   rd_sum;
  logic [RW-1:0] rd_row;
  logic          row_last, col_last, top_last;
  logic          in_range;
  logic [7:0]    rd_byte;

  assign cur_sum  = {1'b0, top_r} + (RW + 1)'(lines_r - LW'(1));
  assign cur_row  = (cur_sum >= (RW + 1)'(ROWS)) ? RW'(cur_sum - (RW + 1)'(ROWS))
                                                  : cur_sum[RW-1:0];
  assign rd_sum   = {1'b0, top_r} + (RW + 1)'(item_r.read_row);
  assign rd_row   = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS))
                                                 : rd_sum[RW-1:0];
  assign row_last = (row_cnt_r == RW'(ROWS - 1));
  assign col_last = (col_cnt_r == CW'(COLS - 1));
  assign top_last = (top_r == RW'(ROWS - 1));
  assign raddr    = {rd_row, CW'(item_r.read_col)};
  assign in_range = (32'(item_r.read_row) < ROWS) && (32'(item_r.read_col) < COLS);
  assign rd_byte  = ((item_r.cmd == CMD_READ) && in_range) ? rd_data_r : CH_NUL;

  assign status.cmd          = item_r.cmd;
  assign status.is_newline   = (item_r.char_code == CH_NEWLINE);
  assign status.is_backspace = (item_r.char_code == CH_BACKSPACE);
  assign status.need_scroll  = (lines_r == LW'(ROWS));
  assign status.need_wrap    = (cursor_r == CW'(COLS - 1));
  assign status.row_last     = row_last;
  assign status.col_last     = col_last;
  assign status.out_free     = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    we            = 1'b0;
    waddr         = '0;
    wdata         = CH_NUL;
    rd_en         = 1'b0;
    lines_nxt     = lines_r;
    cursor_nxt    = cursor_r;
    top_nxt       = top_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (op)
      OP_SWEEP_ALL: begin
        we          = 1'b1;
        waddr       = {row_cnt_r, col_cnt_r};
        col_cnt_nxt = col_last ? '0 : col_cnt_r + CW'(1);
        if (col_last) begin
          row_cnt_nxt = row_last ? '0 : row_cnt_r + RW'(1);
        end
      end
      OP_SWEEP_ROW: begin
        we          = 1'b1;
        waddr       = {scroll_row_r, col_cnt_r};
        col_cnt_nxt = col_last ? '0 : col_cnt_r + CW'(1);
      end
      OP_SWEEP_COL0: begin
        we          = 1'b1;
        waddr       = {row_cnt_r, CW'(0)};
        row_cnt_nxt = row_last ? '0 : row_cnt_r + RW'(1);
      end
      OP_NEWLINE: begin
        cursor_nxt = '0;
        if (lines_r != LW'(ROWS)) begin
          lines_nxt = lines_r + LW'(1);
        end else begin
          top_nxt = top_last ? '0 : top_r + RW'(1);
        end
      end
      OP_BACKSPACE: begin
        if (cursor_r != '0) begin
          cursor_nxt = cursor_r - CW'(1);
          we         = 1'b1;
          waddr      = {cur_row, cursor_r - CW'(1)};
        end
      end
      OP_WRITE_CHAR: begin
        we         = 1'b1;
        waddr      = {cur_row, cursor_r};
        wdata      = item_r.char_code;
        cursor_nxt = cursor_r + CW'(1);
      end
      OP_WRITE_TERM: begin
        we    = 1'b1;
        waddr = {cur_row, cursor_r};
      end
      OP_CLEAR_REGS: begin
        lines_nxt  = LW'(1);
        cursor_nxt = '0;
      end
      OP_READ: begin
        rd_en = 1'b1;
      end
      OP_RESULT: begin
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      item_r <= in_item;
    end
    if (op == OP_NEWLINE) begin
      scroll_row_r <= top_r;
    end
    if (op == OP_RESULT) begin
      out_item_r.cell_data  <= rd_byte;
      out_item_r.line_count <= 6'(lines_r);
      out_item_r.cursor_col <= 7'(cursor_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lines_r     <= LW'(1);
      cursor_r    <= '0;
      top_r       <= '0;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lines_r     <= lines_nxt;
      cursor_r    <= cursor_nxt;
      top_r       <= top_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
    end
  end

endmodule

### hw/rtl/text_console_line_buffer_core.sv
// channel  ports                           direction  transfer when
// input    in_valid, in_ready, in_item     in         in_valid && in_ready
// result   out_valid, out_ready, out_item  out        out_valid && out_ready
//
// after reset a pass zeroes all ROWS*COLS cells of the store; no input is taken meanwhile
// one item at a time; in_ready is high only while the controller is idle
// a newline or wrap that scrolls zeroes a row of COLS cells and a clear zeroes column 0 of
// all ROWS rows, a cell per write, as the character memory has a single write port
// scrolling rotates a top-row pointer and zeroes one row through that port
// a result waiting on out_ready holds the next item in its final cycle
module text_console_line_buffer_core #(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tclb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tclb_pkg::out_item_t out_item
);
  import tclb_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  tclb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  tclb_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .op        (op),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
